/* rtl/bfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_pkg: shared types and constants for the BEEP frame deframer
// Result kinds, error codes, frame types and the front-to-back event record.
// ----------------------------------------------------------------------------
package bfd_pkg;

   localparam int NUM_W  = 31;
   localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   localparam logic [2:0] TYPE_MSG = 3'd0;
   localparam logic [2:0] TYPE_RPY = 3'd1;
   localparam logic [2:0] TYPE_ANS = 3'd2;
   localparam logic [2:0] TYPE_ERR = 3'd3;
   localparam logic [2:0] TYPE_NUL = 3'd4;

   localparam logic [2:0] ERR_KEYWORD = 3'd0;
   localparam logic [2:0] ERR_SPACE   = 3'd1;
   localparam logic [2:0] ERR_INTEGER = 3'd2;
   localparam logic [2:0] ERR_DOT     = 3'd3;
   localparam logic [2:0] ERR_EOL     = 3'd4;
   localparam logic [2:0] ERR_TRAILER = 3'd5;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_E   = 8'h45;
   localparam logic [7:0] CH_N   = 8'h4E;
   localparam logic [7:0] CH_D   = 8'h44;

   // tdata carries everything but kind (tuser) and payload_last (tlast)
   localparam int RSP_DATA_W  = 3 + 5*NUM_W + 8 + 3;            // 169
   localparam int RSP_TDATA_W = ((RSP_DATA_W + 7) / 8) * 8;     // 176

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef struct packed {
      logic [2:0]       err_code;
      logic             pay_last;
      logic [7:0]       pay_byte;
      logic [NUM_W-1:0] answer;
      logic [NUM_W-1:0] size;
      logic [NUM_W-1:0] seq;
      logic [NUM_W-1:0] msg;
      logic [NUM_W-1:0] chan;
      logic [2:0]       ftype;
      logic [1:0]       kind;
   } rsp_type;

   function automatic logic is_blank(input logic [7:0] b);
      return (b == CH_SP) || (b == CH_TAB);
   endfunction

endpackage

/* rtl/beep_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_frame_deframer: BEEP frame parser, one received byte per transaction
// Takes one byte per cycle; results come out of a four-entry queue, and
// input stalls only when that queue is full.
// The result kind travels on rsp_tuser and the last-payload-byte flag on
// rsp_tlast; all other result fields are packed into rsp_tdata.
// ----------------------------------------------------------------------------
module beep_frame_deframer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,   // frame_type, channel_number,
                                     // message_number, sequence_number,
                                     // payload_size, answer_number,
                                     // payload_byte, error_code
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast    // payload_last
);

   logic             ev_valid, q_room;
   bfd_pkg::rsp_type ev, q_data;

   bfd_parser u_parser (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_byte(req_tdata),
      .ev_valid(ev_valid), .ev_room(q_room), .ev(ev)
   );

   bfd_queue u_queue (
      .clock(clock), .reset(reset),
      .wr_valid(ev_valid), .wr_data(ev), .wr_room(q_room),
      .rd_valid(rsp_tvalid), .rd_ready(rsp_tready), .rd_data(q_data)
   );

   assign rsp_tdata = {{(bfd_pkg::RSP_TDATA_W - bfd_pkg::RSP_DATA_W){1'b0}},
                       q_data.err_code, q_data.pay_byte, q_data.answer,
                       q_data.size, q_data.seq, q_data.msg, q_data.chan,
                       q_data.ftype};
   assign rsp_tuser = q_data.kind;
   assign rsp_tlast = q_data.pay_last;

endmodule

/* rtl/bfd_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_parser: byte-level frame parser (front part)
// Walks header, payload, trailer one byte per unstalled cycle; emits events.
// ----------------------------------------------------------------------------
module bfd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_byte,
   output logic               ev_valid,
   input  logic               ev_room,
   output bfd_pkg::rsp_type   ev
);

   typedef enum logic [22:0] {
      KW0     = 23'd1 << 0,  KW1     = 23'd1 << 1,  KW2     = 23'd1 << 2,
      SEP_CH  = 23'd1 << 3,  INT_CH  = 23'd1 << 4,  SEP_MSG = 23'd1 << 5,
      INT_MSG = 23'd1 << 6,  SEP_DOT = 23'd1 << 7,  DOT     = 23'd1 << 8,
      SEP_SEQ = 23'd1 << 9,  INT_SEQ = 23'd1 << 10, SEP_SZ  = 23'd1 << 11,
      INT_SZ  = 23'd1 << 12, SEP_ANS = 23'd1 << 13, INT_ANS = 23'd1 << 14,
      EOL     = 23'd1 << 15, EOL_LF  = 23'd1 << 16, PAYLOAD = 23'd1 << 17,
      TR_E    = 23'd1 << 18, TR_N    = 23'd1 << 19, TR_D    = 23'd1 << 20,
      TR_EOL  = 23'd1 << 21, TR_LF   = 23'd1 << 22
   } phase_type;

   localparam int W = bfd_pkg::NUM_W;

   phase_type        phase_ff, phase_in;
   logic [15:0]      kw_ff, kw_in;
   logic [W-1:0]     acc_ff, acc_in;
   logic             saw_ff, saw_in;
   logic [2:0]       type_ff, type_in;
   logic [W-1:0]     ch_ff, ch_in, msg_ff, msg_in, seq_ff, seq_in;
   logic [W-1:0]     sz_ff, sz_in, ans_ff, ans_in, rem_ff, rem_in;
   logic             err_ff, err_in;

   logic             fire;
   logic             is_digit;
   logic [W+3:0]     acc_x10;
   logic             ovf;
   logic [23:0]      kw_word;
   logic [1:0]       ekind;
   logic [2:0]       ecode;
   logic [7:0]       epbyte;
   logic             eplast;
   logic             emit;
   // results of the separator stage that may follow a finished number
   logic             sep_fail;

   assign in_ready = ev_room;
   assign fire     = in_valid && ev_room && !err_ff;
   assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
   // acc * 10 + digit, as two shifts and adds
   assign acc_x10  = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                   + {{W{1'b0}}, in_byte[3:0]};
   assign ovf      = acc_x10 > {4'd0, bfd_pkg::NUM_MAX};
   assign kw_word  = {kw_ff, in_byte};
   assign sep_fail = !bfd_pkg::is_blank(in_byte);

   always_comb begin
      phase_in = phase_ff; kw_in = kw_ff; acc_in = acc_ff; saw_in = saw_ff;
      type_in = type_ff; ch_in = ch_ff; msg_in = msg_ff; seq_in = seq_ff;
      sz_in = sz_ff; ans_in = ans_ff; rem_in = rem_ff; err_in = err_ff;
      emit = 1'b0; ekind = bfd_pkg::KIND_HEADER; ecode = 3'd0;
      epbyte = 8'd0; eplast = 1'b0;
      if (fire) begin
         unique case (phase_ff)
            KW0: begin
               type_in = 3'd0; ch_in = '0; msg_in = '0; seq_in = '0;
               sz_in = '0; ans_in = '0;
               kw_in = {8'd0, in_byte};
               phase_in = KW1;
            end
            KW1: begin
               kw_in = {kw_ff[7:0], in_byte};
               phase_in = KW2;
            end
            KW2: begin
               phase_in = SEP_CH;
               priority case (kw_word)
                  24'h4D5347: type_in = bfd_pkg::TYPE_MSG;
                  24'h525059: type_in = bfd_pkg::TYPE_RPY;
                  24'h414E53: type_in = bfd_pkg::TYPE_ANS;
                  24'h455252: type_in = bfd_pkg::TYPE_ERR;
                  24'h4E554C: type_in = bfd_pkg::TYPE_NUL;
                  default: begin
                     phase_in = KW2; emit = 1'b1;
                     ekind = bfd_pkg::KIND_ERROR; ecode = bfd_pkg::ERR_KEYWORD;
                  end
               endcase
            end
            SEP_CH, SEP_MSG, SEP_DOT, SEP_SEQ, SEP_SZ, SEP_ANS: begin
               if (sep_fail) begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                  ecode = bfd_pkg::ERR_SPACE;
               end else begin
                  phase_in = phase_type'({phase_ff[21:0], 1'b0});
               end
            end
            INT_CH, INT_MSG, INT_SEQ, INT_SZ, INT_ANS: begin
               if (is_digit) begin
                  if (ovf) begin
                     emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                     ecode = bfd_pkg::ERR_INTEGER;
                  end else begin
                     acc_in = acc_x10[W-1:0];
                     saw_in = 1'b1;
                  end
               end else if (!saw_ff) begin
                  if (sep_fail) begin
                     emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                     ecode = bfd_pkg::ERR_INTEGER;
                  end
               end else begin
                  acc_in = '0; saw_in = 1'b0;
                  // the terminating byte is checked here as the following separator
                  priority case (1'b1)
                     phase_ff[4]: begin
                        ch_in = acc_ff;
                        if (sep_fail) begin
                           emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                           ecode = bfd_pkg::ERR_SPACE; phase_in = SEP_MSG;
                        end else phase_in = INT_MSG;
                     end
                     phase_ff[6]: begin
                        msg_in = acc_ff;
                        if (sep_fail) begin
                           emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                           ecode = bfd_pkg::ERR_SPACE; phase_in = SEP_DOT;
                        end else phase_in = DOT;
                     end
                     phase_ff[10]: begin
                        seq_in = acc_ff;
                        if (sep_fail) begin
                           emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                           ecode = bfd_pkg::ERR_SPACE; phase_in = SEP_SZ;
                        end else phase_in = INT_SZ;
                     end
                     default: begin
                        if (phase_ff[12]) sz_in = acc_ff;
                        else ans_in = acc_ff;
                        if (phase_ff[12] && type_ff == bfd_pkg::TYPE_ANS) begin
                           if (sep_fail) begin
                              emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                              ecode = bfd_pkg::ERR_SPACE; phase_in = SEP_ANS;
                           end else phase_in = INT_ANS;
                        end else if (in_byte == bfd_pkg::CH_CR) begin
                           phase_in = EOL_LF;
                        end else if (in_byte == bfd_pkg::CH_LF) begin
                           // header done straight from the number
                           emit = 1'b1; ekind = bfd_pkg::KIND_HEADER;
                           rem_in = phase_ff[12] ? acc_ff : sz_ff;
                           phase_in = ((phase_ff[12] ? acc_ff : sz_ff) != '0)
                                    ? PAYLOAD : TR_E;
                        end else begin
                           emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                           ecode = bfd_pkg::ERR_EOL; phase_in = EOL;
                        end
                     end
                  endcase
               end
            end
            DOT: begin
               if (in_byte == bfd_pkg::CH_DOT) phase_in = SEP_SEQ;
               else if (sep_fail) begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                  ecode = bfd_pkg::ERR_DOT;
               end
            end
            EOL, EOL_LF: begin
               if (phase_ff[15] && in_byte == bfd_pkg::CH_CR) phase_in = EOL_LF;
               else if (in_byte != bfd_pkg::CH_LF) begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                  ecode = bfd_pkg::ERR_EOL;
               end else begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_HEADER;
                  rem_in = sz_ff;
                  phase_in = (sz_ff != '0) ? PAYLOAD : TR_E;
               end
            end
            PAYLOAD: begin
               emit = 1'b1; ekind = bfd_pkg::KIND_PAYLOAD;
               epbyte = in_byte;
               eplast = (rem_ff <= {{(W-1){1'b0}}, 1'b1});
               rem_in = eplast ? '0 : rem_ff - {{(W-1){1'b0}}, 1'b1};
               if (eplast) phase_in = TR_E;
            end
            TR_E, TR_N, TR_D: begin
               if ((phase_ff[18] && in_byte != bfd_pkg::CH_E) ||
                   (phase_ff[19] && in_byte != bfd_pkg::CH_N) ||
                   (phase_ff[20] && in_byte != bfd_pkg::CH_D)) begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                  ecode = bfd_pkg::ERR_TRAILER;
               end else begin
                  phase_in = phase_type'({phase_ff[21:0], 1'b0});
               end
            end
            TR_EOL, TR_LF: begin
               if (phase_ff[21] && in_byte == bfd_pkg::CH_CR) phase_in = TR_LF;
               else if (in_byte != bfd_pkg::CH_LF) begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_ERROR;
                  ecode = bfd_pkg::ERR_TRAILER;
               end else begin
                  emit = 1'b1; ekind = bfd_pkg::KIND_END;
                  phase_in = KW0;
               end
            end
            default: phase_in = KW0;
         endcase
         if (emit && ekind == bfd_pkg::KIND_ERROR) err_in = 1'b1;
      end
   end

   assign ev_valid    = emit;
   assign ev.kind     = ekind;
   assign ev.ftype    = type_in;
   assign ev.chan     = ch_in;
   assign ev.msg      = msg_in;
   assign ev.seq      = seq_in;
   assign ev.size     = sz_in;
   assign ev.answer   = ans_in;
   assign ev.pay_byte = epbyte;
   assign ev.pay_last = eplast;
   assign ev.err_code = ecode;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= KW0; kw_ff <= '0; acc_ff <= '0; saw_ff <= 1'b0;
         type_ff <= '0; ch_ff <= '0; msg_ff <= '0; seq_ff <= '0;
         sz_ff <= '0; ans_ff <= '0; rem_ff <= '0; err_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; kw_ff <= kw_in; acc_ff <= acc_in; saw_ff <= saw_in;
         type_ff <= type_in; ch_ff <= ch_in; msg_ff <= msg_in; seq_ff <= seq_in;
         sz_ff <= sz_in; ans_ff <= ans_in; rem_ff <= rem_in; err_ff <= err_in;
      end
   end

endmodule

/* rtl/bfd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfd_queue: result queue (back part)
// Small FIFO that holds parsed events until the result channel takes them.
// ----------------------------------------------------------------------------
module bfd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   input  bfd_pkg::rsp_type wr_data,
   output logic             wr_room,
   output logic             rd_valid,
   input  logic             rd_ready,
   output bfd_pkg::rsp_type rd_data
);

   localparam int AW = bfd_pkg::FIFO_AW;

   bfd_pkg::rsp_type mem_ff [bfd_pkg::FIFO_DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign wr_room  = cnt_ff != (AW+1)'(bfd_pkg::FIFO_DEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign do_wr    = wr_valid;
   assign do_rd    = rd_valid && rd_ready;
   assign wp_in    = do_wr ? wp_ff + AW'(1) : wp_ff;
   assign rp_in    = do_rd ? rp_ff + AW'(1) : rp_ff;
   assign cnt_in   = cnt_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end

endmodule

/* sim/tb_beep_frame_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_beep_frame_deframer: self-checking bench for the BEEP frame deframer
// Streams well-formed frames with random content through the parser, with
// bursty input and a stalling receiver. A scoreboard predicts each result.
// One malformation closes the run, since the error stays sticky.
// ----------------------------------------------------------------------------
module tb_beep_frame_deframer;

   typedef enum int {
      P_KW0, P_KW1, P_KW2, P_SEP_CH, P_INT_CH, P_SEP_MSG, P_INT_MSG,
      P_SEP_DOT, P_DOT, P_SEP_SEQ, P_INT_SEQ, P_SEP_SIZE, P_INT_SIZE,
      P_SEP_ANS, P_INT_ANS, P_EOL, P_EOL_LF, P_PAYLOAD, P_TR_E, P_TR_N,
      P_TR_D, P_TR_EOL, P_TR_LF
   } phase_e;

   class frame_scoreboard;
      phase_e     phase;
      logic [15:0] kw_shift;
      logic [31:0] acc;
      bit         got_digit;
      logic [2:0] ftype;
      logic [bfd_pkg::NUM_W-1:0] chan, msg, seq, size, answer, remaining;
      bit         stuck;
      bfd_pkg::rsp_type pending[$];
      int         errors;

      function void clear();
         phase = P_KW0; kw_shift = '0; acc = '0; got_digit = 0;
         ftype = '0; chan = '0; msg = '0; seq = '0; size = '0; answer = '0;
         remaining = '0; stuck = 0; errors = 0;
      endfunction

      function bfd_pkg::rsp_type make(logic [1:0] k, logic [7:0] pb, logic pl,
                                      logic [2:0] ec);
         bfd_pkg::rsp_type r;
         r.kind = k; r.ftype = ftype; r.chan = chan; r.msg = msg; r.seq = seq;
         r.size = size; r.answer = answer; r.pay_byte = pb; r.pay_last = pl;
         r.err_code = ec;
         return r;
      endfunction

      // 0: nothing, 1: result in r, 2: byte must be parsed again
      function int parse(logic [7:0] b, output bfd_pkg::rsp_type r);
         logic [23:0] w;
         logic [63:0] v;
         bit blank;
         blank = (b == bfd_pkg::CH_SP) || (b == bfd_pkg::CH_TAB);
         r = '0;
         case (phase)
            P_KW0: begin
               ftype = '0; chan = '0; msg = '0; seq = '0; size = '0; answer = '0;
               kw_shift = {8'h00, b}; phase = P_KW1; return 0;
            end
            P_KW1: begin
               kw_shift = {kw_shift[7:0], b}; phase = P_KW2; return 0;
            end
            P_KW2: begin
               w = {kw_shift, b};
               phase = P_SEP_CH;
               if (w == "MSG") ftype = bfd_pkg::TYPE_MSG;
               else if (w == "RPY") ftype = bfd_pkg::TYPE_RPY;
               else if (w == "ANS") ftype = bfd_pkg::TYPE_ANS;
               else if (w == "ERR") ftype = bfd_pkg::TYPE_ERR;
               else if (w == "NUL") ftype = bfd_pkg::TYPE_NUL;
               else begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_KEYWORD);
                  return 1;
               end
               return 0;
            end
            P_SEP_CH, P_SEP_MSG, P_SEP_DOT, P_SEP_SEQ, P_SEP_SIZE, P_SEP_ANS: begin
               if (!blank) begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_SPACE);
                  return 1;
               end
               phase = phase_e'(phase + 1); return 0;
            end
            P_INT_CH, P_INT_MSG, P_INT_SEQ, P_INT_SIZE, P_INT_ANS: begin
               if (b >= "0" && b <= "9") begin
                  v = 64'(acc) * 10 + 64'(b - "0");
                  if (v > 64'(bfd_pkg::NUM_MAX)) begin
                     stuck = 1;
                     r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_INTEGER);
                     return 1;
                  end
                  acc = v[31:0]; got_digit = 1; return 0;
               end
               if (!got_digit) begin
                  if (blank) return 0;
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_INTEGER);
                  return 1;
               end
               case (phase)
                  P_INT_CH:  begin chan = acc[30:0]; phase = P_SEP_MSG; end
                  P_INT_MSG: begin msg = acc[30:0]; phase = P_SEP_DOT; end
                  P_INT_SEQ: begin seq = acc[30:0]; phase = P_SEP_SIZE; end
                  P_INT_SIZE: begin
                     size = acc[30:0];
                     phase = (ftype == bfd_pkg::TYPE_ANS) ? P_SEP_ANS : P_EOL;
                  end
                  default: begin answer = acc[30:0]; phase = P_EOL; end
               endcase
               acc = '0; got_digit = 0;
               return 2;
            end
            P_DOT: begin
               if (blank) return 0;
               if (b != bfd_pkg::CH_DOT) begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_DOT);
                  return 1;
               end
               phase = P_SEP_SEQ; return 0;
            end
            P_EOL, P_EOL_LF: begin
               if (phase == P_EOL && b == bfd_pkg::CH_CR) begin
                  phase = P_EOL_LF; return 0;
               end
               if (b != bfd_pkg::CH_LF) begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_EOL);
                  return 1;
               end
               remaining = size;
               phase = (remaining != 0) ? P_PAYLOAD : P_TR_E;
               r = make(bfd_pkg::KIND_HEADER, 0, 0, 0); return 1;
            end
            P_PAYLOAD: begin
               r = make(bfd_pkg::KIND_PAYLOAD, b, remaining <= 1, 0);
               if (remaining <= 1) begin
                  remaining = 0; phase = P_TR_E;
               end else remaining = remaining - 1;
               return 1;
            end
            P_TR_E, P_TR_N, P_TR_D: begin
               if ((phase == P_TR_E && b != bfd_pkg::CH_E) ||
                   (phase == P_TR_N && b != bfd_pkg::CH_N) ||
                   (phase == P_TR_D && b != bfd_pkg::CH_D)) begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_TRAILER);
                  return 1;
               end
               phase = phase_e'(phase + 1); return 0;
            end
            P_TR_EOL, P_TR_LF: begin
               if (phase == P_TR_EOL && b == bfd_pkg::CH_CR) begin
                  phase = P_TR_LF; return 0;
               end
               if (b != bfd_pkg::CH_LF) begin
                  stuck = 1;
                  r = make(bfd_pkg::KIND_ERROR, 0, 0, bfd_pkg::ERR_TRAILER);
                  return 1;
               end
               phase = P_KW0;
               r = make(bfd_pkg::KIND_END, 0, 0, 0); return 1;
            end
            default: begin phase = P_KW0; return 0; end
         endcase
      endfunction

      function void note_byte(logic [7:0] b);
         bfd_pkg::rsp_type r;
         int s;
         if (stuck) return;
         s = parse(b, r);
         if (s == 2) s = parse(b, r);
         if (s == 1) pending.push_back(r);
      endfunction

      function void check_result(logic [175:0] data, logic [1:0] user, logic last);
         bfd_pkg::rsp_type want;
         logic [175:0] exp_data;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result, actual %h", $time, data);
            errors++;
            return;
         end
         want = pending.pop_front();
         exp_data = {{(bfd_pkg::RSP_TDATA_W - bfd_pkg::RSP_DATA_W){1'b0}},
                     want.err_code, want.pay_byte, want.answer, want.size,
                     want.seq, want.msg, want.chan, want.ftype};
         if (data !== exp_data) begin
            $display("%0t: tdata mismatch, expected %h actual %h", $time, exp_data, data);
            errors++;
         end
         if (user !== want.kind) begin
            $display("%0t: tuser mismatch, expected %h actual %h", $time, want.kind, user);
            errors++;
         end
         if (last !== want.pay_last) begin
            $display("%0t: tlast mismatch, expected %b actual %b", $time, want.pay_last, last);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [175:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   frame_scoreboard sb;
   logic [7:0] byte_q[$];
   int cycles = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   beep_frame_deframer i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 300000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver: stretches of full rate alternate with random stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      if (reset) rsp_tready <= 1'b0;
      else if (cycles[9:8] == 2'd0) rsp_tready <= 1'b1;
      else if (cycles[9:8] == 2'd1) rsp_tready <= ($urandom_range(0, 7) == 0);
      else rsp_tready <= ($urandom_range(0, 2) != 0);
   end

   function automatic void push_str(string s);
      for (int i = 0; i < s.len(); i++) byte_q.push_back(s[i]);
   endfunction

   function automatic void push_blanks();
      int n;
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
         byte_q.push_back($urandom_range(0, 1) ? bfd_pkg::CH_SP : bfd_pkg::CH_TAB);
   endfunction

   function automatic void push_num(logic [30:0] v);
      if ($urandom_range(0, 5) == 0) push_str("00");
      push_str($sformatf("%0d", v));
   endfunction

   function automatic logic [30:0] rand_num();
      case ($urandom_range(0, 3))
         0: return 31'($urandom_range(0, 9));
         1: return bfd_pkg::NUM_MAX;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 9999));
      endcase
   endfunction

   function automatic void push_eol(bit cr);
      if (cr) byte_q.push_back(bfd_pkg::CH_CR);
      byte_q.push_back(bfd_pkg::CH_LF);
   endfunction

   function automatic void push_frame(logic [2:0] ft, logic [30:0] ch, logic [30:0] mn,
                                      logic [30:0] sq, int sz, logic [30:0] an, bit cr);
      case (ft)
         bfd_pkg::TYPE_MSG: push_str("MSG");
         bfd_pkg::TYPE_RPY: push_str("RPY");
         bfd_pkg::TYPE_ANS: push_str("ANS");
         bfd_pkg::TYPE_ERR: push_str("ERR");
         default:  push_str("NUL");
      endcase
      push_blanks(); push_num(ch);
      push_blanks(); push_num(mn);
      push_blanks(); byte_q.push_back(bfd_pkg::CH_DOT);
      push_blanks(); push_num(sq);
      push_blanks(); push_num(31'(sz));
      if (ft == bfd_pkg::TYPE_ANS) begin
         push_blanks(); push_num(an);
      end
      push_eol(cr);
      for (int i = 0; i < sz; i++) byte_q.push_back(8'($urandom));
      push_str("END");
      push_eol($urandom_range(0, 1));
   endfunction

   function automatic void push_random_frame();
      int sz;
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      push_frame(3'($urandom_range(0, 4)), rand_num(), rand_num(), rand_num(), sz,
                 rand_num(), $urandom_range(0, 1));
   endfunction

   // single closing malformation; the error is sticky so only one per run
   function automatic void push_bad_frame();
      case ($urandom_range(0, 8))
         0: push_str("MSX 1 2 . 3 0\n");
         1: push_str("MSG1 2 . 3 0\n");
         2: push_str("MSG -1 2 . 3 0\n");
         3: push_str("RPY 2147483648 2 . 3 0\n");
         4: push_str("MSG 1 2 3 0\n");
         5: push_str("MSG 1 2 . 3 0 \n");
         6: push_str("ANS 1 2 . 3 0 4\rX");
         7: push_str("NUL 1 2 . 3 1\r\nZENX\n");
         default: push_str("ERR 1 2 . 3 0\nEND\rQ");
      endcase
      for (int i = 0; i < 10; i++) byte_q.push_back(8'($urandom));
   endfunction

   initial begin
      int gap, burst, tail;
      sb = new();
      sb.clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed frames
      push_frame(bfd_pkg::TYPE_MSG, 0, 0, 0, 0, 0, 1);
      push_frame(bfd_pkg::TYPE_RPY, bfd_pkg::NUM_MAX, bfd_pkg::NUM_MAX,
                 bfd_pkg::NUM_MAX, 2, 0, 0);
      // payload bytes sit before END and a one- or two-byte line end
      tail = (byte_q[byte_q.size() - 2] == bfd_pkg::CH_CR) ? 7 : 6;
      byte_q[byte_q.size() - tail] = 8'h00;
      byte_q[byte_q.size() - tail + 1] = 8'hFF;
      push_frame(bfd_pkg::TYPE_ANS, 7, 1, 5, 1, bfd_pkg::NUM_MAX, 1);
      push_frame(bfd_pkg::TYPE_ERR, 3, 4, 5, 0, 0, 0);
      push_frame(bfd_pkg::TYPE_NUL, 1, 2, 3, 0, 0, 1);
      push_frame(bfd_pkg::TYPE_ANS, 0, 0, 0, 0, 0, 0);
      while (byte_q.size() < 570) push_random_frame();
      push_bad_frame();

      @(posedge clock);
      while (byte_q.size() != 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst = $urandom_range(1, 30);
         while (burst > 0 && byte_q.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= byte_q[0];
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            sb.note_byte(byte_q.pop_front());
            burst--;
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
